[rtl/shabs_pkg.sv]
package shabs_pkg;

  typedef logic [31:0] word_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT_RD,
    ST_OUT_LOAD,
    ST_OUT_HOLD
  } state_t;

  // What follows a compression
  typedef enum logic [1:0] {
    JOB_IDLE,
    JOB_PAD,
    JOB_OUT
  } job_t;

  localparam int BlockWords = 16;
  localparam int HashWords  = 8;
  localparam int RoundCount = 64;

  localparam logic [7:0] PadByte   = 8'h80;
  localparam logic [3:0] LenHiWord = 4'd14;
  localparam logic [3:0] LenLoWord = 4'd15;
  localparam logic [3:0] LastWord  = 4'd15;
  localparam logic [5:0] LastRound = 6'd63;
  localparam logic [5:0] LoadDone  = 6'd16;
  localparam logic [5:0] FoldDone  = 6'd8;
  localparam logic [5:0] LastByte  = 6'd63;
  localparam logic [2:0] LastIndex = 3'd7;

  function automatic word_t rotr(input word_t x, input int s);
    rotr = (x >> s) | (x << (32 - s));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  // Initial chaining value
  function automatic word_t init_hash(input logic [2:0] idx);
    case (idx)
      3'd0:    init_hash = 32'h6a09e667;
      3'd1:    init_hash = 32'hbb67ae85;
      3'd2:    init_hash = 32'h3c6ef372;
      3'd3:    init_hash = 32'ha54ff53a;
      3'd4:    init_hash = 32'h510e527f;
      3'd5:    init_hash = 32'h9b05688c;
      3'd6:    init_hash = 32'h1f83d9ab;
      default: init_hash = 32'h5be0cd19;
    endcase
  endfunction

  // Round constants
  function automatic word_t round_k(input logic [5:0] t);
    case (t)
      6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;
      default: round_k = 32'hc67178f2;
    endcase
  endfunction

endpackage

[rtl/shabs_ram.sv]
module shabs_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/sha256_byte_stream_hash.sv]
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  in_data_byte, in_has_byte, in_end_of_message
// out_     output     out_valid/out_stall out_digest_word, out_word_index, out_last_word
//
// A byte transaction is accepted only while idle; the 64th byte of a block adds one compression.
// A compression loads schedule and chaining value from the two RAMs, runs 64 rounds,
// then folds the result back into the chaining RAM.
// End of message: 1 to 16 padding writes per padded block, one or two compressions,
// then each digest word is read, loaded and held until out_stall is low. in_stall is high whenever busy.
// Reset (rst_n low, synchronous) restores the initial hash; no clearing pass.
module sha256_byte_stream_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import shabs_pkg::*;

  // Control state
  state_t      state_r, state_nxt;
  job_t        job_r, job_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bitlen_r, bitlen_nxt;
  logic [7:0]  hv_r, hv_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_idx_r, out_idx_nxt;
  logic [3:0]  pad_idx_r, pad_idx_nxt;
  logic        pad_first_r, pad_first_nxt;
  logic        len_blk_r, len_blk_nxt;
  logic        rd_init_r;

  // Datapath
  word_t       acc_r, acc_nxt;
  word_t       v_r [HashWords];
  word_t       v_nxt [HashWords];
  word_t       w_r [BlockWords];
  word_t       w_nxt [BlockWords];
  word_t       out_word_r, out_word_nxt;
  logic [2:0]  rd_addr_r;

  // RAM ports
  logic        blk_we, blk_re;
  logic [3:0]  blk_waddr, blk_raddr;
  word_t       blk_wdata, blk_rdata;
  logic        hash_we, hash_re;
  logic [2:0]  hash_waddr, hash_raddr;
  word_t       hash_wdata, hash_rdata, hash_eff;

  // Round and merge terms
  word_t       t1, t2, w_new, merged, base;
  logic [7:0]  byte_sel;
  logic [4:0]  byte_sh;
  logic        accept;
  logic [2:0]  fold_addr;

  shabs_ram #(.Width(32), .Depth(BlockWords)) u_blk_ram (
    .clk   (clk),
    .we    (blk_we),
    .waddr (blk_waddr),
    .wdata (blk_wdata),
    .re    (blk_re),
    .raddr (blk_raddr),
    .rdata (blk_rdata)
  );

  shabs_ram #(.Width(32), .Depth(HashWords)) u_hash_ram (
    .clk   (clk),
    .we    (hash_we),
    .waddr (hash_waddr),
    .wdata (hash_wdata),
    .re    (hash_re),
    .raddr (hash_raddr),
    .rdata (hash_rdata)
  );

  // Entries not written since reset read as the initial hash
  assign hash_eff = rd_init_r ? init_hash(rd_addr_r) : hash_rdata;

  assign accept    = in_valid && (state_r == ST_IDLE);
  assign fold_addr = 3'(cnt_r - 6'd1);

  // Place a byte into the word under assembly
  assign byte_sel = (state_r == ST_IDLE) ? in_data_byte : PadByte;
  assign byte_sh  = {~fill_r[1:0], 3'b000};
  assign base     = (fill_r[1:0] == 2'd0) ? '0 : acc_r;
  assign merged   = base | (word_t'(byte_sel) << byte_sh);

  // One compression round and one schedule step
  assign t1 = v_r[7] + big_sigma1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + round_k(cnt_r) + w_r[0];
  assign t2 = big_sigma0(v_r[0])
            + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  assign w_new = small_sigma1(w_r[14]) + w_r[9] + small_sigma0(w_r[1]) + w_r[0];

  // Next state, RAM controls and datapath updates
  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    cnt_nxt       = cnt_r;
    fill_nxt      = fill_r;
    bitlen_nxt    = bitlen_r;
    hv_nxt        = hv_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    pad_idx_nxt   = pad_idx_r;
    pad_first_nxt = pad_first_r;
    len_blk_nxt   = len_blk_r;
    acc_nxt       = acc_r;
    out_word_nxt  = out_word_r;
    v_nxt         = v_r;
    w_nxt         = w_r;
    blk_we        = 1'b0;
    blk_waddr     = fill_r[5:2];
    blk_wdata     = merged;
    blk_re        = 1'b0;
    blk_raddr     = cnt_r[3:0];
    hash_we       = 1'b0;
    hash_waddr    = fold_addr;
    hash_wdata    = hash_eff + v_r[0];
    hash_re       = 1'b0;
    hash_raddr    = cnt_r[2:0];

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // Store the byte and count it
          if (in_has_byte) begin
            blk_we     = 1'b1;
            acc_nxt    = merged;
            fill_nxt   = fill_r + 6'd1;
            bitlen_nxt = bitlen_r + 64'd8;
          end
          pad_idx_nxt   = fill_nxt[5:2];
          pad_first_nxt = 1'b1;
          len_blk_nxt   = (fill_nxt[5:2] < LenHiWord);
          if (in_has_byte && fill_r == LastByte) begin
            state_nxt = ST_LOAD;
            cnt_nxt   = '0;
            job_nxt   = in_end_of_message ? JOB_PAD : JOB_IDLE;
          end else if (in_end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end

      ST_PAD: begin
        // Write one padding word per cycle
        blk_we        = 1'b1;
        blk_waddr     = pad_idx_r;
        pad_first_nxt = 1'b0;
        if (pad_first_r) begin
          blk_wdata = merged;
        end else if (len_blk_r && pad_idx_r == LenHiWord) begin
          blk_wdata = bitlen_r[63:32];
        end else if (len_blk_r && pad_idx_r == LenLoWord) begin
          blk_wdata = bitlen_r[31:0];
        end else begin
          blk_wdata = '0;
        end
        if (pad_idx_r == LastWord) begin
          state_nxt = ST_LOAD;
          cnt_nxt   = '0;
          job_nxt   = len_blk_r ? JOB_OUT : JOB_PAD;
        end else begin
          pad_idx_nxt = pad_idx_r + 4'd1;
        end
      end

      ST_LOAD: begin
        // Stream block words and chaining value into the working registers
        blk_re  = (cnt_r < LoadDone);
        hash_re = (cnt_r < 6'(HashWords));
        if (cnt_r != '0) begin
          for (int i = 0; i < BlockWords - 1; i++) begin
            w_nxt[i] = w_r[i+1];
          end
          w_nxt[BlockWords-1] = blk_rdata;
        end
        if (cnt_r != '0 && cnt_r <= 6'(HashWords)) begin
          for (int i = 0; i < HashWords - 1; i++) begin
            v_nxt[i] = v_r[i+1];
          end
          v_nxt[HashWords-1] = hash_eff;
        end
        if (cnt_r == LoadDone) begin
          state_nxt = ST_ROUND;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end

      ST_ROUND: begin
        // Advance the working variables and the schedule
        v_nxt[0] = t1 + t2;
        v_nxt[1] = v_r[0];
        v_nxt[2] = v_r[1];
        v_nxt[3] = v_r[2];
        v_nxt[4] = v_r[3] + t1;
        v_nxt[5] = v_r[4];
        v_nxt[6] = v_r[5];
        v_nxt[7] = v_r[6];
        for (int i = 0; i < BlockWords - 1; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        w_nxt[BlockWords-1] = w_new;
        if (cnt_r == LastRound) begin
          state_nxt = ST_FOLD;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end

      ST_FOLD: begin
        // Read-add-write each chaining word, rotating the working set
        hash_re = (cnt_r < 6'(HashWords));
        if (cnt_r != '0) begin
          hash_we           = 1'b1;
          hv_nxt[fold_addr] = 1'b1;
          for (int i = 0; i < HashWords - 1; i++) begin
            v_nxt[i] = v_r[i+1];
          end
          v_nxt[HashWords-1] = v_r[0];
        end
        if (cnt_r == FoldDone) begin
          cnt_nxt = '0;
          case (job_r)
            JOB_PAD: begin
              // Keep pad_first: still set when the end came with a full block
              state_nxt   = ST_PAD;
              pad_idx_nxt = '0;
              len_blk_nxt = 1'b1;
            end
            JOB_OUT: begin
              state_nxt   = ST_OUT_RD;
              out_idx_nxt = '0;
              fill_nxt    = '0;
              bitlen_nxt  = '0;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end

      ST_OUT_RD: begin
        hash_re    = 1'b1;
        hash_raddr = out_idx_r;
        state_nxt  = ST_OUT_LOAD;
      end

      ST_OUT_LOAD: begin
        out_word_nxt  = hash_eff;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_OUT_HOLD;
      end

      ST_OUT_HOLD: begin
        // Hold the word until taken; after the last, drop back to the initial hash
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_idx_r == LastIndex) begin
            hv_nxt    = '0;
            state_nxt = ST_IDLE;
          end else begin
            out_idx_nxt = out_idx_r + 3'd1;
            state_nxt   = ST_OUT_RD;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      job_r       <= JOB_IDLE;
      cnt_r       <= '0;
      fill_r      <= '0;
      bitlen_r    <= '0;
      hv_r        <= '0;
      out_valid_r <= 1'b0;
      out_idx_r   <= '0;
      pad_idx_r   <= '0;
      pad_first_r <= 1'b0;
      len_blk_r   <= 1'b0;
      rd_init_r   <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      job_r       <= job_nxt;
      cnt_r       <= cnt_nxt;
      fill_r      <= fill_nxt;
      bitlen_r    <= bitlen_nxt;
      hv_r        <= hv_nxt;
      out_valid_r <= out_valid_nxt;
      out_idx_r   <= out_idx_nxt;
      pad_idx_r   <= pad_idx_nxt;
      pad_first_r <= pad_first_nxt;
      len_blk_r   <= len_blk_nxt;
      if (hash_re) begin
        rd_init_r <= !hv_r[hash_raddr];
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    out_word_r <= out_word_nxt;
    v_r        <= v_nxt;
    w_r        <= w_nxt;
    if (hash_re) begin
      rd_addr_r <= hash_raddr;
    end
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_index  = out_idx_r;
  assign out_last_word   = (out_idx_r == LastIndex);

endmodule

[rtl/shabs_checker.sv]
module shabs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_data_byte,
  input logic        in_has_byte,
  input logic        in_end_of_message,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_last_word
);
  import shabs_pkg::*;

  // A stalled digest word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_digest_word)
      && $stable(out_word_index))
    else $error("digest word changed while stalled");

  // No input transaction while the digest drains
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open during digest output");

  // Last flag marks the final index
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == LastIndex)))
    else $error("last flag does not match word index");

  // Each word needs a fresh read before the next is shown
  a_word_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_word |=> !out_valid)
    else $error("digest words shown back to back");

  // After the last word the block is ready for a new message
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_word |=> !in_stall && !out_valid)
    else $error("block not idle after digest");

endmodule

bind sha256_byte_stream_hash shabs_checker u_shabs_checker (.*);
